FILE: src/rvdec_pkg.sv
// Package: operation numbers, opcode and field constants, configuration types for the decoder.
`default_nettype none

package rvdec_pkg;

   // Operation numbers, densely packed; zero marks an unsupported word.
   typedef enum logic [6:0] {
      OP_ILLEGAL = 7'd0,
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
      OP_FENCE,
      OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRAI, OP_SRLI,
      OP_AUIPC,
      OP_SB, OP_SH, OP_SW,
      OP_LR_W, OP_SC_W, OP_AMOSWAP, OP_AMOADD, OP_AMOXOR, OP_AMOAND, OP_AMOOR,
      OP_AMOMIN, OP_AMOMAX, OP_AMOMINU, OP_AMOMAXU,
      OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU,
      OP_LUI,
      OP_BEQ, OP_BNE, OP_BLT, OP_BLTU, OP_BGE, OP_BGEU,
      OP_JALR, OP_JAL,
      OP_SFENCE_VMA, OP_EBREAK,
      OP_HALT, OP_DUMP, OP_TRACE_SET, OP_TRACE_RESET, OP_CSR_DUMP,
      OP_ECALL, OP_SRET, OP_MRET, OP_WFI,
      OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI
   } op_type;

   localparam int unsigned INSTR_W = 32;
   localparam int unsigned OP_W    = 7;
   localparam int unsigned CODE_W  = 12;
   localparam int unsigned CSR_IDX_W = 3;

   // Major opcodes
   localparam logic [6:0] OPC_LOAD     = 7'h03;
   localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
   localparam logic [6:0] OPC_OP_IMM   = 7'h13;
   localparam logic [6:0] OPC_AUIPC    = 7'h17;
   localparam logic [6:0] OPC_STORE    = 7'h23;
   localparam logic [6:0] OPC_AMO      = 7'h2F;
   localparam logic [6:0] OPC_OP       = 7'h33;
   localparam logic [6:0] OPC_LUI      = 7'h37;
   localparam logic [6:0] OPC_BRANCH   = 7'h63;
   localparam logic [6:0] OPC_JALR     = 7'h67;
   localparam logic [6:0] OPC_JAL      = 7'h6F;
   localparam logic [6:0] OPC_SYSTEM   = 7'h73;

   // funct7 values
   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [6:0] F7_SFENCE = 7'h09;

   // AMO funct5 values
   localparam logic [4:0] F5_AMOADD  = 5'h00;
   localparam logic [4:0] F5_AMOSWAP = 5'h01;
   localparam logic [4:0] F5_LR      = 5'h02;
   localparam logic [4:0] F5_SC      = 5'h03;
   localparam logic [4:0] F5_AMOXOR  = 5'h04;
   localparam logic [4:0] F5_AMOOR   = 5'h08;
   localparam logic [4:0] F5_AMOAND  = 5'h0C;
   localparam logic [4:0] F5_AMOMIN  = 5'h10;
   localparam logic [4:0] F5_AMOMAX  = 5'h14;
   localparam logic [4:0] F5_AMOMINU = 5'h18;
   localparam logic [4:0] F5_AMOMAXU = 5'h1C;

   localparam logic [2:0] F3_AMO_W = 3'd2;

   // Standard SYSTEM immediates
   localparam logic [CODE_W-1:0] IMM_ECALL  = 12'h000;
   localparam logic [CODE_W-1:0] IMM_EBREAK = 12'h001;
   localparam logic [CODE_W-1:0] IMM_SRET   = 12'h102;
   localparam logic [CODE_W-1:0] IMM_WFI    = 12'h105;
   localparam logic [CODE_W-1:0] IMM_MRET   = 12'h302;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUSTOM_ENABLE = 3'd0,
      CSR_HALT_CODE     = 3'd1,
      CSR_DUMP_CODE     = 3'd2,
      CSR_TRACE_SET     = 3'd3,
      CSR_TRACE_RESET   = 3'd4,
      CSR_CSR_DUMP      = 3'd5
   } csr_index_type;

   // Reset values of the custom codes
   localparam logic [CODE_W-1:0] RST_HALT_CODE   = 12'h8C0;
   localparam logic [CODE_W-1:0] RST_DUMP_CODE   = 12'h8C1;
   localparam logic [CODE_W-1:0] RST_TRACE_SET   = 12'h8C2;
   localparam logic [CODE_W-1:0] RST_TRACE_RESET = 12'h8C3;
   localparam logic [CODE_W-1:0] RST_CSR_DUMP    = 12'h8C4;

   typedef struct packed {
      logic              custom_enable;
      logic [CODE_W-1:0] halt_code;
      logic [CODE_W-1:0] dump_code;
      logic [CODE_W-1:0] trace_set_code;
      logic [CODE_W-1:0] trace_reset_code;
      logic [CODE_W-1:0] csr_dump_code;
   } cfg_type;

endpackage

`default_nettype wire

FILE: src/rvdec_if.sv
// Interfaces: instruction request channel and decode response channel.
`default_nettype none

interface rvdec_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvdec_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] operation;
   logic       is_illegal;

   modport source (output valid, output operation, output is_illegal, input ready);
   modport sink   (input valid, input operation, input is_illegal, output ready);
endinterface

`default_nettype wire

FILE: src/rvdec_csr.sv
// Configuration registers: custom enable and the five custom SYSTEM codes.
`default_nettype none

module rvdec_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [rvdec_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rvdec_pkg::CODE_W-1:0]      csr_wdata,
   output rvdec_pkg::cfg_type                     cfg
);
   import rvdec_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CUSTOM_ENABLE: cfg_in.custom_enable    = csr_wdata[0];
            CSR_HALT_CODE:     cfg_in.halt_code        = csr_wdata;
            CSR_DUMP_CODE:     cfg_in.dump_code        = csr_wdata;
            CSR_TRACE_SET:     cfg_in.trace_set_code   = csr_wdata;
            CSR_TRACE_RESET:   cfg_in.trace_reset_code = csr_wdata;
            CSR_CSR_DUMP:      cfg_in.csr_dump_code    = csr_wdata;
            default:           cfg_in = cfg_ff; // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.custom_enable    <= 1'b1;
         cfg_ff.halt_code        <= RST_HALT_CODE;
         cfg_ff.dump_code        <= RST_DUMP_CODE;
         cfg_ff.trace_set_code   <= RST_TRACE_SET;
         cfg_ff.trace_reset_code <= RST_TRACE_RESET;
         cfg_ff.csr_dump_code    <= RST_CSR_DUMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/rvdec_decode.sv
// Combinational field matcher: instruction word to operation number.
`default_nettype none

module rvdec_decode (
   input  wire logic [rvdec_pkg::INSTR_W-1:0] instr_word,
   input  rvdec_pkg::cfg_type                 cfg,
   output rvdec_pkg::op_type                  operation
);
   import rvdec_pkg::*;

   logic [6:0]        opc;
   logic [2:0]        f3;
   logic [6:0]        f7;
   logic [4:0]        f5;
   logic [4:0]        rs2;
   logic [CODE_W-1:0] imm12;
   op_type            priv_op;

   assign opc   = instr_word[6:0];
   assign f3    = instr_word[14:12];
   assign f7    = instr_word[31:25];
   assign f5    = instr_word[31:27];
   assign rs2   = instr_word[24:20];
   assign imm12 = instr_word[31:20];

   // Privileged group: standard immediates win over custom codes,
   // lower custom operation wins among equal codes.
   always_comb begin
      priority if (f7 == F7_SFENCE)                   priv_op = OP_SFENCE_VMA;
      else if (imm12 == IMM_ECALL)                    priv_op = OP_ECALL;
      else if (imm12 == IMM_EBREAK)                   priv_op = OP_EBREAK;
      else if (imm12 == IMM_SRET)                     priv_op = OP_SRET;
      else if (imm12 == IMM_WFI)                      priv_op = OP_WFI;
      else if (imm12 == IMM_MRET)                     priv_op = OP_MRET;
      else if (!cfg.custom_enable)                    priv_op = OP_ILLEGAL;
      else if (imm12 == cfg.halt_code)                priv_op = OP_HALT;
      else if (imm12 == cfg.dump_code)                priv_op = OP_DUMP;
      else if (imm12 == cfg.trace_set_code)           priv_op = OP_TRACE_SET;
      else if (imm12 == cfg.trace_reset_code)         priv_op = OP_TRACE_RESET;
      else if (imm12 == cfg.csr_dump_code)            priv_op = OP_CSR_DUMP;
      else                                            priv_op = OP_ILLEGAL;
   end

   always_comb begin
      operation = OP_ILLEGAL;
      case (opc)
         OPC_LOAD: begin
            case (f3)
               3'd0:    operation = OP_LB;
               3'd1:    operation = OP_LH;
               3'd2:    operation = OP_LW;
               3'd4:    operation = OP_LBU;
               3'd5:    operation = OP_LHU;
               default: operation = OP_ILLEGAL;
            endcase
         end
         OPC_MISC_MEM: operation = (f3 == 3'd0) ? OP_FENCE : OP_ILLEGAL;
         OPC_OP_IMM: begin
            unique case (f3)
               3'd0: operation = OP_ADDI;
               3'd1: operation = (f7 == F7_BASE) ? OP_SLLI : OP_ILLEGAL;
               3'd2: operation = OP_SLTI;
               3'd3: operation = OP_SLTIU;
               3'd4: operation = OP_XORI;
               3'd5: begin
                  priority if (f7 == F7_ALT) operation = OP_SRAI;
                  else if (f7 == F7_BASE)    operation = OP_SRLI;
                  else                       operation = OP_ILLEGAL;
               end
               3'd6: operation = OP_ORI;
               3'd7: operation = OP_ANDI;
            endcase
         end
         OPC_AUIPC: operation = OP_AUIPC;
         OPC_STORE: begin
            case (f3)
               3'd0:    operation = OP_SB;
               3'd1:    operation = OP_SH;
               3'd2:    operation = OP_SW;
               default: operation = OP_ILLEGAL;
            endcase
         end
         OPC_AMO: begin
            if (f3 == F3_AMO_W) begin
               case (f5)
                  F5_AMOADD:  operation = OP_AMOADD;
                  F5_AMOSWAP: operation = OP_AMOSWAP;
                  F5_LR:      operation = (rs2 == 5'd0) ? OP_LR_W : OP_ILLEGAL;
                  F5_SC:      operation = OP_SC_W;
                  F5_AMOXOR:  operation = OP_AMOXOR;
                  F5_AMOOR:   operation = OP_AMOOR;
                  F5_AMOAND:  operation = OP_AMOAND;
                  F5_AMOMIN:  operation = OP_AMOMIN;
                  F5_AMOMAX:  operation = OP_AMOMAX;
                  F5_AMOMINU: operation = OP_AMOMINU;
                  F5_AMOMAXU: operation = OP_AMOMAXU;
                  default:    operation = OP_ILLEGAL;
               endcase
            end
         end
         OPC_OP: begin
            if (f7 == F7_BASE) begin
               unique case (f3)
                  3'd0: operation = OP_ADD;
                  3'd1: operation = OP_SLL;
                  3'd2: operation = OP_SLT;
                  3'd3: operation = OP_SLTU;
                  3'd4: operation = OP_XOR;
                  3'd5: operation = OP_SRL;
                  3'd6: operation = OP_OR;
                  3'd7: operation = OP_AND;
               endcase
            end else if (f7 == F7_MULDIV) begin
               unique case (f3)
                  3'd0: operation = OP_MUL;
                  3'd1: operation = OP_MULH;
                  3'd2: operation = OP_MULHSU;
                  3'd3: operation = OP_MULHU;
                  3'd4: operation = OP_DIV;
                  3'd5: operation = OP_DIVU;
                  3'd6: operation = OP_REM;
                  3'd7: operation = OP_REMU;
               endcase
            end else if (f7 == F7_ALT) begin
               case (f3)
                  3'd0:    operation = OP_SUB;
                  3'd5:    operation = OP_SRA;
                  default: operation = OP_ILLEGAL;
               endcase
            end
         end
         OPC_LUI: operation = OP_LUI;
         OPC_BRANCH: begin
            case (f3)
               3'd0:    operation = OP_BEQ;
               3'd1:    operation = OP_BNE;
               3'd4:    operation = OP_BLT;
               3'd5:    operation = OP_BGE;
               3'd6:    operation = OP_BLTU;
               3'd7:    operation = OP_BGEU;
               default: operation = OP_ILLEGAL;
            endcase
         end
         OPC_JALR: operation = (f3 == 3'd0) ? OP_JALR : OP_ILLEGAL;
         OPC_JAL:  operation = OP_JAL;
         OPC_SYSTEM: begin
            unique case (f3)
               3'd0: operation = priv_op;
               3'd1: operation = OP_CSRRW;
               3'd2: operation = OP_CSRRS;
               3'd3: operation = OP_CSRRC;
               3'd4: operation = OP_ILLEGAL;
               3'd5: operation = OP_CSRRWI;
               3'd6: operation = OP_CSRRSI;
               3'd7: operation = OP_CSRRCI;
            endcase
         end
         default: operation = OP_ILLEGAL;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/rv32ima_instruction_decoder.sv
// Top level: RV32IMA instruction decoder with input and result registers.
`default_nettype none

// Decodes one 32-bit RV32IMA instruction word per transfer into an operation
// number (1 to 74) plus an illegal flag; operation 0 with is_illegal high marks
// an unsupported word. The path is two registers deep: a transfer accepted on
// req is held in the input register, decoded from it and captured into the
// result register, which offers it on rsp. While rsp is ready, a new transfer
// is taken every cycle, so sustained rate is one instruction per clock. The
// only logic between the two registers is the field matcher, which compares
// opcode, funct3, funct7/funct5, rs2 and the 12-bit SYSTEM immediate. Both
// stages hold under back-pressure; req.ready stays high while either stage has
// room, so the input side takes one more transfer while a finished result
// waits and then stalls until rsp drains.
// The csr_ port writes the custom-op enable (index 0) and the five custom
// SYSTEM codes (indexes 1 to 5: halt, dump, trace on, trace off, CSR dump);
// other indexes are dropped. Write it only while no transfer is in flight.
// Standard SYSTEM immediates always take priority over a custom code.
module rv32ima_instruction_decoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rvdec_req_if.sink                             req,
   rvdec_rsp_if.source                           rsp,
   input  wire logic                             csr_wr_en,
   input  wire logic [rvdec_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rvdec_pkg::CODE_W-1:0]     csr_wdata
);
   import rvdec_pkg::*;

   cfg_type             cfg;
   op_type              dec_op;

   // Input stage
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [INSTR_W-1:0]  in_word_ff;
   logic [INSTR_W-1:0]  in_word_in;

   // Result stage
   logic                out_valid_ff;
   logic                out_valid_in;
   op_type              out_op_ff;
   op_type              out_op_in;

   logic                out_room;
   logic                in_room;

   rvdec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rvdec_decode u_decode (
      .instr_word (in_word_ff),
      .cfg        (cfg),
      .operation  (dec_op)
   );

   // A stage has room when it is empty or its contents leave this cycle.
   assign out_room  = !out_valid_ff || rsp.ready;
   assign in_room   = !in_valid_ff || out_room;
   assign req.ready = in_room;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (in_room) begin
         // advance: take the new transfer, or go empty
         in_valid_in = req.valid;
         if (req.valid) begin
            in_word_in = req.instr_word;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_op_in    = out_op_ff;
      if (out_room) begin
         // advance: capture the decoded operation from the input stage
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_op_in = dec_op;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      out_op_ff  <= out_op_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.operation  = OP_W'(out_op_ff);
   assign rsp.is_illegal = (out_op_ff == OP_ILLEGAL);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for the RV32IMA instruction decoder: random and directed words checked against a local decode.
`timescale 1ns / 1ps

module tb;
   import rvdec_pkg::*;

   // funct3 values used by the local decode and the word builders
   localparam logic [2:0] F3_BYTE     = 3'd0;
   localparam logic [2:0] F3_HALF     = 3'd1;
   localparam logic [2:0] F3_WORD     = 3'd2;
   localparam logic [2:0] F3_BYTE_U   = 3'd4;
   localparam logic [2:0] F3_HALF_U   = 3'd5;
   localparam logic [2:0] F3_ADD      = 3'd0;
   localparam logic [2:0] F3_SLL      = 3'd1;
   localparam logic [2:0] F3_SLT      = 3'd2;
   localparam logic [2:0] F3_SLTU     = 3'd3;
   localparam logic [2:0] F3_XOR      = 3'd4;
   localparam logic [2:0] F3_SR       = 3'd5;
   localparam logic [2:0] F3_OR       = 3'd6;
   localparam logic [2:0] F3_AND      = 3'd7;
   localparam logic [2:0] F3_BEQ      = 3'd0;
   localparam logic [2:0] F3_BNE      = 3'd1;
   localparam logic [2:0] F3_BLT      = 3'd4;
   localparam logic [2:0] F3_BGE      = 3'd5;
   localparam logic [2:0] F3_BLTU     = 3'd6;
   localparam logic [2:0] F3_BGEU     = 3'd7;
   localparam logic [2:0] F3_FENCE    = 3'd0;
   localparam logic [2:0] F3_JALR     = 3'd0;
   localparam logic [2:0] F3_AMO_D    = 3'd3;
   localparam logic [2:0] F3_PRIV     = 3'd0;
   localparam logic [2:0] F3_CSRRW    = 3'd1;
   localparam logic [2:0] F3_CSRRS    = 3'd2;
   localparam logic [2:0] F3_CSRRC    = 3'd3;
   localparam logic [2:0] F3_SYS_RSVD = 3'd4;
   localparam logic [2:0] F3_CSRRWI   = 3'd5;
   localparam logic [2:0] F3_CSRRSI   = 3'd6;
   localparam logic [2:0] F3_CSRRCI   = 3'd7;

   // index past the last register; writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   // cycles without any transfer while work is pending before giving up
   localparam int unsigned STUCK_LIMIT = 2000;

   typedef struct {
      logic [INSTR_W-1:0] word;
      op_type             operation;
      logic               is_illegal;
   } decode_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CODE_W-1:0]    csr_wdata;

   rvdec_req_if req_if ();
   rvdec_rsp_if rsp_if ();

   rv32ima_instruction_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the decoder configuration, tracked on every register write.
   cfg_type decode_cfg;

   logic [INSTR_W-1:0] queued_instrs[$];
   decode_type         expected_decodes[$];
   int unsigned        error_count;

   // sender burst/gap bookkeeping and receiver stall pattern
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stall_mode;
   int unsigned stall_window;
   int unsigned stuck_cycles;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Decode one word the way the block should under configuration c.
   function automatic op_type decode_instr(logic [INSTR_W-1:0] w, cfg_type c);
      logic [2:0]        f3;
      logic [6:0]        f7;
      logic [CODE_W-1:0] imm;
      op_type            op;
      f3  = w[14:12];
      f7  = w[31:25];
      imm = w[31:20];
      op  = OP_ILLEGAL;
      case (w[6:0])
         OPC_LOAD: begin
            case (f3)
               F3_BYTE:   op = OP_LB;
               F3_HALF:   op = OP_LH;
               F3_WORD:   op = OP_LW;
               F3_BYTE_U: op = OP_LBU;
               F3_HALF_U: op = OP_LHU;
               default:   ;
            endcase
         end
         OPC_MISC_MEM: if (f3 == F3_FENCE) op = OP_FENCE;
         OPC_OP_IMM: begin
            case (f3)
               F3_ADD:  op = OP_ADDI;
               F3_SLT:  op = OP_SLTI;
               F3_SLTU: op = OP_SLTIU;
               F3_XOR:  op = OP_XORI;
               F3_OR:   op = OP_ORI;
               F3_AND:  op = OP_ANDI;
               // shift immediates: funct7 must match exactly
               F3_SLL:  if (f7 == F7_BASE) op = OP_SLLI;
               F3_SR: begin
                  if (f7 == F7_ALT) op = OP_SRAI;
                  else if (f7 == F7_BASE) op = OP_SRLI;
               end
               default: ;
            endcase
         end
         OPC_AUIPC: op = OP_AUIPC;
         OPC_STORE: begin
            case (f3)
               F3_BYTE: op = OP_SB;
               F3_HALF: op = OP_SH;
               F3_WORD: op = OP_SW;
               default: ;
            endcase
         end
         OPC_AMO: begin
            // aq/rl (bits 26:25) are don't-care; only word width decodes
            if (f3 == F3_AMO_W) begin
               case (w[31:27])
                  F5_AMOADD:  op = OP_AMOADD;
                  F5_AMOSWAP: op = OP_AMOSWAP;
                  F5_LR:      if (w[24:20] == 5'd0) op = OP_LR_W;
                  F5_SC:      op = OP_SC_W;
                  F5_AMOXOR:  op = OP_AMOXOR;
                  F5_AMOOR:   op = OP_AMOOR;
                  F5_AMOAND:  op = OP_AMOAND;
                  F5_AMOMIN:  op = OP_AMOMIN;
                  F5_AMOMAX:  op = OP_AMOMAX;
                  F5_AMOMINU: op = OP_AMOMINU;
                  F5_AMOMAXU: op = OP_AMOMAXU;
                  default:    ;
               endcase
            end
         end
         OPC_OP: begin
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  op = OP_ADD;
                  F3_SLL:  op = OP_SLL;
                  F3_SLT:  op = OP_SLT;
                  F3_SLTU: op = OP_SLTU;
                  F3_XOR:  op = OP_XOR;
                  F3_SR:   op = OP_SRL;
                  F3_OR:   op = OP_OR;
                  F3_AND:  op = OP_AND;
                  default: ;
               endcase
            end else if (f7 == F7_MULDIV) begin
               // MUL..REMU follow funct3 in order
               op = op_type'(OP_MUL + f3);
            end else if (f7 == F7_ALT) begin
               if (f3 == F3_ADD) op = OP_SUB;
               else if (f3 == F3_SR) op = OP_SRA;
            end
         end
         OPC_LUI: op = OP_LUI;
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  op = OP_BEQ;
               F3_BNE:  op = OP_BNE;
               F3_BLT:  op = OP_BLT;
               F3_BGE:  op = OP_BGE;
               F3_BLTU: op = OP_BLTU;
               F3_BGEU: op = OP_BGEU;
               default: ;
            endcase
         end
         OPC_JALR: if (f3 == F3_JALR) op = OP_JALR;
         OPC_JAL:  op = OP_JAL;
         OPC_SYSTEM: begin
            case (f3)
               F3_PRIV: begin
                  // SFENCE.VMA ignores everything but funct7; otherwise the
                  // full immediate decides, standard codes ahead of custom ones
                  if (f7 == F7_SFENCE) begin
                     op = OP_SFENCE_VMA;
                  end else begin
                     case (imm)
                        IMM_ECALL:  op = OP_ECALL;
                        IMM_EBREAK: op = OP_EBREAK;
                        IMM_SRET:   op = OP_SRET;
                        IMM_WFI:    op = OP_WFI;
                        IMM_MRET:   op = OP_MRET;
                        default: begin
                           if (c.custom_enable) begin
                              if (imm == c.halt_code) op = OP_HALT;
                              else if (imm == c.dump_code) op = OP_DUMP;
                              else if (imm == c.trace_set_code) op = OP_TRACE_SET;
                              else if (imm == c.trace_reset_code) op = OP_TRACE_RESET;
                              else if (imm == c.csr_dump_code) op = OP_CSR_DUMP;
                           end
                        end
                     endcase
                  end
               end
               F3_CSRRW:  op = OP_CSRRW;
               F3_CSRRS:  op = OP_CSRRS;
               F3_CSRRC:  op = OP_CSRRC;
               F3_CSRRWI: op = OP_CSRRWI;
               F3_CSRRSI: op = OP_CSRRSI;
               F3_CSRRCI: op = OP_CSRRCI;
               default:   ;
            endcase
         end
         default: ;
      endcase
      return op;
   endfunction

   function automatic logic [CODE_W-1:0] std_system_imm();
      case ($urandom_range(0, 4))
         0:       return IMM_ECALL;
         1:       return IMM_EBREAK;
         2:       return IMM_SRET;
         3:       return IMM_WFI;
         default: return IMM_MRET;
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] custom_system_imm();
      case ($urandom_range(0, 4))
         0:       return decode_cfg.halt_code;
         1:       return decode_cfg.dump_code;
         2:       return decode_cfg.trace_set_code;
         3:       return decode_cfg.trace_reset_code;
         default: return decode_cfg.csr_dump_code;
      endcase
   endfunction

   // SYSTEM privileged-group word with the given immediate and random rs1/rd
   function automatic logic [INSTR_W-1:0] sys_word(logic [CODE_W-1:0] imm);
      return {imm, 5'($urandom), F3_PRIV, 5'($urandom), OPC_SYSTEM};
   endfunction

   function automatic logic [6:0] shift_funct7();
      case ($urandom_range(0, 3))
         0:       return F7_BASE;
         1:       return F7_ALT;
         2:       return F7_MULDIV;
         default: return 7'($urandom);
      endcase
   endfunction

   // Mostly well-formed words with random register fields; some pure noise.
   function automatic logic [INSTR_W-1:0] random_instr();
      logic [INSTR_W-1:0] w;
      w = $urandom();
      if ($urandom_range(0, 99) < 8) return w;
      case ($urandom_range(0, 14))
         0: w[6:0] = OPC_LOAD;
         1: begin
            w[6:0] = OPC_MISC_MEM;
            if ($urandom_range(0, 3) != 0) w[14:12] = F3_FENCE;
         end
         2: begin
            w[6:0] = OPC_OP_IMM;
            if (w[13:12] == 2'b01) w[31:25] = shift_funct7();
         end
         3: w[6:0] = OPC_AUIPC;
         4: w[6:0] = OPC_STORE;
         5, 6: begin
            w[6:0] = OPC_AMO;
            if ($urandom_range(0, 5) != 0) w[14:12] = F3_AMO_W;
            if ($urandom_range(0, 5) != 0) begin
               case ($urandom_range(0, 10))
                  0:       w[31:27] = F5_AMOADD;
                  1:       w[31:27] = F5_AMOSWAP;
                  2:       w[31:27] = F5_LR;
                  3:       w[31:27] = F5_SC;
                  4:       w[31:27] = F5_AMOXOR;
                  5:       w[31:27] = F5_AMOOR;
                  6:       w[31:27] = F5_AMOAND;
                  7:       w[31:27] = F5_AMOMIN;
                  8:       w[31:27] = F5_AMOMAX;
                  9:       w[31:27] = F5_AMOMINU;
                  default: w[31:27] = F5_AMOMAXU;
               endcase
            end
            if (w[31:27] == F5_LR && $urandom_range(0, 2) != 0) w[24:20] = 5'd0;
         end
         7: begin
            w[6:0] = OPC_OP;
            w[31:25] = shift_funct7();
         end
         8:  w[6:0] = OPC_LUI;
         9:  w[6:0] = OPC_BRANCH;
         10: begin
            w[6:0] = OPC_JALR;
            if ($urandom_range(0, 3) != 0) w[14:12] = F3_JALR;
         end
         11: w[6:0] = OPC_JAL;
         default: begin
            w[6:0] = OPC_SYSTEM;
            if ($urandom_range(0, 1) == 0) w[14:12] = F3_PRIV;
            if (w[14:12] == F3_PRIV) begin
               case ($urandom_range(0, 9))
                  0:             w[31:25] = F7_SFENCE;
                  1, 2, 3, 4:    w[31:20] = std_system_imm();
                  5, 6, 7, 8:    w[31:20] = custom_system_imm();
                  default:       ;
               endcase
            end
         end
      endcase
      return w;
   endfunction

   // Drive one register write; the block samples it at the next edge.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CUSTOM_ENABLE: decode_cfg.custom_enable    = data[0];
         CSR_HALT_CODE:     decode_cfg.halt_code        = data;
         CSR_DUMP_CODE:     decode_cfg.dump_code        = data;
         CSR_TRACE_SET:     decode_cfg.trace_set_code   = data;
         CSR_TRACE_RESET:   decode_cfg.trace_reset_code = data;
         CSR_CSR_DUMP:      decode_cfg.csr_dump_code    = data;
         default:           ;
      endcase
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Block until every queued word went in and every result came back.
   task automatic wait_drained();
      @(posedge clock);
      while (queued_instrs.size() != 0 || req_if.valid || expected_decodes.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random(int unsigned count);
      repeat (count) queued_instrs.push_back(random_instr());
      wait_drained();
   endtask

   // Request driver: pop queued words in bursts, hold each word until its transfer.
   always @(posedge clock) begin : req_driver
      logic               transfer;
      logic               next_valid;
      logic [INSTR_W-1:0] next_word;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         transfer = req_if.valid && req_if.ready;
         if (transfer) begin
            expected_decodes.push_back('{req_if.instr_word,
                                         decode_instr(req_if.instr_word, decode_cfg),
                                         decode_instr(req_if.instr_word, decode_cfg)
                                            == OP_ILLEGAL});
         end
         next_valid = req_if.valid && !transfer;
         next_word  = req_if.instr_word;
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (queued_instrs.size() != 0) begin
               next_valid = 1'b1;
               next_word  = queued_instrs.pop_front();
               // at the end of a burst pick the next gap, often none at all
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
         req_if.valid      <= next_valid;
         req_if.instr_word <= next_word;
      end
   end

   // Response monitor: check each transfer against the oldest expectation,
   // and stall ready with a random pattern that changes whenever its window runs out.
   always @(posedge clock) begin : rsp_monitor
      decode_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_mode   = 0;
         stall_window = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_decodes.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected: operation %0d is_illegal %0b",
                        $time, rsp_if.operation, rsp_if.is_illegal);
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_if.operation !== want.operation) begin
                  error_count++;
                  $display("%0t: instr %08h operation expected %0d (%s) actual %0d",
                           $time, want.word, want.operation, want.operation.name(),
                           rsp_if.operation);
               end
               if (rsp_if.is_illegal !== want.is_illegal) begin
                  error_count++;
                  $display("%0t: instr %08h is_illegal expected %0b actual %0b",
                           $time, want.word, want.is_illegal, rsp_if.is_illegal);
               end
            end
         end
         if (stall_window == 0) begin
            stall_mode   = $urandom_range(0, 3);
            stall_window = $urandom_range(8, 40);
         end else begin
            stall_window--;
         end
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 1) == 0);
            2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= stall_window[1];
         endcase
      end
   end

   // Watchdog: count cycles with pending work and no transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (queued_instrs.size() == 0 && !req_if.valid && expected_decodes.size() == 0)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, stuck_cycles, expected_decodes.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int unsigned en_bit;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.instr_word = '0;
      rsp_if.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_CUSTOM_ENABLE;
      csr_wdata         = '0;
      error_count       = 0;
      stuck_cycles      = 0;
      decode_cfg.custom_enable    = 1'b1;
      decode_cfg.halt_code        = RST_HALT_CODE;
      decode_cfg.dump_code        = RST_DUMP_CODE;
      decode_cfg.trace_set_code   = RST_TRACE_SET;
      decode_cfg.trace_reset_code = RST_TRACE_RESET;
      decode_cfg.csr_dump_code    = RST_CSR_DUMP;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: field extremes and the special cases.
      queued_instrs.push_back(32'h0000_0000);
      queued_instrs.push_back(32'hFFFF_FFFF);
      queued_instrs.push_back({F7_BASE, 5'h1F, 5'h1F, F3_SLL, 5'h1F, OPC_OP_IMM});
      queued_instrs.push_back({F7_ALT, 5'h01, 5'h02, F3_SLL, 5'h03, OPC_OP_IMM});
      queued_instrs.push_back({F7_ALT, 5'h04, 5'h05, F3_SR, 5'h06, OPC_OP_IMM});
      queued_instrs.push_back({F7_BASE, 5'h07, 5'h08, F3_SR, 5'h09, OPC_OP_IMM});
      queued_instrs.push_back({F7_MULDIV, 5'h0A, 5'h0B, F3_SR, 5'h0C, OPC_OP_IMM});
      queued_instrs.push_back({F7_ALT, 5'h0D, 5'h0E, F3_XOR, 5'h0F, OPC_OP});
      queued_instrs.push_back({F5_AMOADD, 2'b11, 5'h1F, 5'h1F, F3_AMO_W, 5'h1F, OPC_AMO});
      queued_instrs.push_back({F5_AMOSWAP, 2'b00, 5'h01, 5'h02, F3_AMO_D, 5'h03, OPC_AMO});
      queued_instrs.push_back({F5_LR, 2'b11, 5'h00, 5'h1F, F3_AMO_W, 5'h1F, OPC_AMO});
      queued_instrs.push_back({F5_LR, 2'b00, 5'h10, 5'h01, F3_AMO_W, 5'h02, OPC_AMO});
      queued_instrs.push_back({F5_SC, 2'b01, 5'h1F, 5'h00, F3_AMO_W, 5'h00, OPC_AMO});
      queued_instrs.push_back({F7_SFENCE, 5'h1F, 5'h1F, F3_PRIV, 5'h1F, OPC_SYSTEM});
      queued_instrs.push_back(sys_word(IMM_ECALL));
      queued_instrs.push_back(sys_word(IMM_EBREAK));
      queued_instrs.push_back(sys_word(IMM_SRET));
      queued_instrs.push_back(sys_word(IMM_WFI));
      queued_instrs.push_back(sys_word(IMM_MRET));
      queued_instrs.push_back(sys_word(RST_HALT_CODE));
      queued_instrs.push_back(sys_word(RST_DUMP_CODE));
      queued_instrs.push_back(sys_word(RST_TRACE_SET));
      queued_instrs.push_back(sys_word(RST_TRACE_RESET));
      queued_instrs.push_back(sys_word(RST_CSR_DUMP));
      queued_instrs.push_back(sys_word(12'hFFF));
      queued_instrs.push_back({12'h300, 5'h01, F3_SYS_RSVD, 5'h02, OPC_SYSTEM});
      queued_instrs.push_back({12'h0FF, 5'h00, F3_HALF, 5'h00, OPC_MISC_MEM});
      run_random(150);

      // Custom codes off: upper data bits set to show only bit 0 counts.
      csr_write(CSR_CUSTOM_ENABLE, 12'hFFE);
      csr_done();
      queued_instrs.push_back(sys_word(decode_cfg.halt_code));
      queued_instrs.push_back(sys_word(decode_cfg.dump_code));
      queued_instrs.push_back(sys_word(decode_cfg.trace_set_code));
      queued_instrs.push_back(sys_word(decode_cfg.trace_reset_code));
      queued_instrs.push_back(sys_word(decode_cfg.csr_dump_code));
      queued_instrs.push_back(sys_word(IMM_ECALL));
      run_random(80);

      // Collisions: custom codes on standard immediates and on each other,
      // plus a write to an index past the last register that must be dropped.
      csr_write(CSR_CUSTOM_ENABLE, 12'hFFF);
      csr_write(CSR_HALT_CODE, IMM_ECALL);
      csr_write(CSR_DUMP_CODE, 12'hFFF);
      csr_write(CSR_TRACE_SET, 12'hFFF);
      csr_write(CSR_TRACE_RESET, IMM_MRET);
      csr_write(CSR_CSR_DUMP, 12'h7FF);
      csr_write(CSR_UNUSED_IDX, 12'h8C5);
      csr_done();
      queued_instrs.push_back(sys_word(IMM_ECALL));
      queued_instrs.push_back(sys_word(12'hFFF));
      queued_instrs.push_back(sys_word(IMM_MRET));
      queued_instrs.push_back(sys_word(12'h7FF));
      queued_instrs.push_back(sys_word(12'h8C5));
      run_random(100);

      // Random settings; codes often repeat another code or a standard value.
      repeat (3) begin
         en_bit = ($urandom_range(0, 3) != 0);
         csr_write(CSR_CUSTOM_ENABLE, {11'($urandom), en_bit[0]});
         for (int idx = CSR_HALT_CODE; idx <= CSR_CSR_DUMP; idx++) begin
            case ($urandom_range(0, 3))
               0:       csr_write(idx[CSR_IDX_W-1:0], decode_cfg.halt_code);
               1:       csr_write(idx[CSR_IDX_W-1:0], std_system_imm());
               default: csr_write(idx[CSR_IDX_W-1:0], 12'($urandom));
            endcase
         end
         csr_done();
         run_random(70);
      end

      // let the two-stage pipe settle so a stray late result would be seen
      repeat (4) @(posedge clock);
      if (error_count == 0 && expected_decodes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
